/* sv/eerd_pkg.sv */
// ----------------------------------------------------------------------------
// eerd_pkg
// Shared types, codes and helpers for the paged serial EEPROM read sequencer.
// ----------------------------------------------------------------------------
package eerd_pkg;

   // Command codes of an input item.
   localparam logic [1:0] CMD_EVENT    = 2'd0;
   localparam logic [1:0] CMD_SET_PAGE = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;

   // Bus action codes of a result item.
   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_SEND  = 3'd2;
   localparam logic [2:0] ACT_RECV  = 3'd3;
   localparam logic [2:0] ACT_STOP  = 3'd4;

   // Expected TWI status codes.
   localparam logic [7:0] TWI_START_OK  = 8'h08;
   localparam logic [7:0] TWI_SLA_W_ACK = 8'h18;
   localparam logic [7:0] TWI_DATA_ACK  = 8'h28;
   localparam logic [7:0] TWI_SLA_R_ACK = 8'h40;
   localparam logic [7:0] TWI_DATA_NACK = 8'h58;

   localparam logic [7:0] DEVICE_BASE_RESET = 8'hA0;
   localparam int         WRAP_PAGES_DEFAULT = 512;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [10:0] page;
      logic [7:0]  bus_status;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_action;
      logic [7:0] tx_byte;
      logic       done_res;
      logic       failed;
      logic [7:0] done_value;
      logic       busy_res;
   } rsp_type;

   // Device select byte for a page: the top three page bits become the
   // chip and block bits just above the read/write bit.
   function automatic logic [7:0] page_dsel(input logic [7:0] base, input logic [10:0] pg);
      page_dsel = base | {4'b0000, pg[10:8], 1'b0};
   endfunction

   // Word address of the first byte of a page.
   function automatic logic [15:0] page_addr(input logic [10:0] pg);
      page_addr = {pg[7:0], 8'h00};
   endfunction

endpackage

/* sv/eerd_ctrl.sv */
// ----------------------------------------------------------------------------
// eerd_ctrl
// Sequencer state and the combinational decision taken for each item.
// ----------------------------------------------------------------------------
module eerd_ctrl #(
   parameter int WRAP_PAGES = eerd_pkg::WRAP_PAGES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  eerd_pkg::req_type req,
   input  logic [7:0]       device_base,
   output eerd_pkg::rsp_type res
);
   import eerd_pkg::*;

   localparam logic [10:0] WrapMask = 11'(WRAP_PAGES - 1);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_SP_DEV  = 9'b000000010,
      ST_SP_MSB  = 9'b000000100,
      ST_SP_LSB  = 9'b000001000,
      ST_SP_STOP = 9'b000010000,
      ST_RD_DEV  = 9'b000100000,
      ST_RD_NACK = 9'b001000000,
      ST_RD_DATA = 9'b010000000,
      ST_AUTO    = 9'b100000000
   } step_type;

   step_type    step_ff, step_in;
   logic [10:0] page_ff, page_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  dsel_ff, dsel_in;
   logic        pend_ff, pend_in;

   logic [7:0]  expected;
   logic [15:0] addr_inc;
   logic [10:0] page_inc;
   logic [10:0] page_new;

   always_comb begin
      unique case (step_ff)
         ST_SP_DEV, ST_RD_DEV:   expected = TWI_START_OK;
         ST_SP_MSB:              expected = TWI_SLA_W_ACK;
         ST_SP_LSB, ST_SP_STOP:  expected = TWI_DATA_ACK;
         ST_RD_NACK:             expected = TWI_SLA_R_ACK;
         ST_RD_DATA:             expected = TWI_DATA_NACK;
         default:                expected = TWI_START_OK;
      endcase
   end

   assign addr_inc = addr_ff + 16'd1;
   assign page_inc = page_ff + 11'd1;
   // A page step onto a 64 KB boundary folds the page into the wrap range.
   assign page_new = (page_inc[7:0] == 8'h00) ? (page_inc & WrapMask) : page_inc;

   always_comb begin
      step_in = step_ff;
      page_in = page_ff;
      addr_in = addr_ff;
      dsel_in = dsel_ff;
      pend_in = pend_ff;
      res     = '0;
      unique case (step_ff)
         ST_IDLE: begin
            if (req.cmd == CMD_SET_PAGE) begin
               page_in        = req.page;
               dsel_in        = page_dsel(device_base, req.page);
               addr_in        = page_addr(req.page);
               pend_in        = 1'b0;
               step_in        = ST_SP_DEV;
               res.bus_action = ACT_START;
            end else if (req.cmd == CMD_READ) begin
               step_in        = ST_RD_DEV;
               res.bus_action = ACT_START;
            end
         end
         ST_AUTO: begin
            step_in        = ST_SP_DEV;
            res.bus_action = ACT_START;
         end
         ST_SP_DEV, ST_SP_MSB, ST_SP_LSB, ST_SP_STOP,
         ST_RD_DEV, ST_RD_NACK, ST_RD_DATA: begin
            if (req.cmd != CMD_EVENT) begin
               // Commands are ignored while an operation runs.
            end else if (req.bus_status != expected) begin
               res.bus_action = ACT_STOP;
               res.done_res   = ~pend_ff;
               res.failed     = 1'b1;
               res.done_value = req.bus_status;
               pend_in        = 1'b0;
               step_in        = ST_IDLE;
            end else begin
               unique case (step_ff)
                  ST_SP_DEV: begin
                     step_in        = ST_SP_MSB;
                     res.bus_action = ACT_SEND;
                     res.tx_byte    = dsel_ff & 8'hFE;
                  end
                  ST_SP_MSB: begin
                     step_in        = ST_SP_LSB;
                     res.bus_action = ACT_SEND;
                     res.tx_byte    = addr_ff[15:8];
                  end
                  ST_SP_LSB: begin
                     step_in        = ST_SP_STOP;
                     res.bus_action = ACT_SEND;
                     res.tx_byte    = addr_ff[7:0];
                  end
                  ST_SP_STOP: begin
                     step_in        = ST_IDLE;
                     res.bus_action = ACT_STOP;
                     res.done_res   = ~pend_ff;
                     pend_in        = 1'b0;
                  end
                  ST_RD_DEV: begin
                     step_in        = ST_RD_NACK;
                     res.bus_action = ACT_SEND;
                     res.tx_byte    = dsel_ff | 8'h01;
                  end
                  ST_RD_NACK: begin
                     step_in        = ST_RD_DATA;
                     res.bus_action = ACT_RECV;
                  end
                  ST_RD_DATA: begin
                     step_in        = ST_IDLE;
                     res.bus_action = ACT_STOP;
                     res.done_res   = 1'b1;
                     res.done_value = req.rx_byte;
                     if (addr_inc[7:0] != 8'h00) begin
                        addr_in = addr_inc;
                     end else begin
                        page_in = page_new;
                        dsel_in = page_dsel(device_base, page_new);
                        addr_in = page_addr(page_new);
                        if (page_inc[7:0] == 8'h00) begin
                           pend_in = 1'b1;
                           step_in = ST_AUTO;
                        end
                     end
                  end
                  default: begin
                     step_in = ST_IDLE;
                     pend_in = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            step_in = ST_IDLE;
            pend_in = 1'b0;
         end
      endcase
      res.busy_res = (step_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         page_ff <= '0;
         addr_ff <= '0;
         dsel_ff <= '0;
         pend_ff <= 1'b0;
      end else if (accept) begin
         step_ff <= step_in;
         page_ff <= page_in;
         addr_ff <= addr_in;
         dsel_ff <= dsel_in;
         pend_ff <= pend_in;
      end
   end

endmodule

/* sv/i2c_eeprom_read_sequencer_top.sv */
// ----------------------------------------------------------------------------
// i2c_eeprom_read_sequencer_top: read sequencer for a paged serial EEPROM.
// An item's result is valid in the cycle after it is accepted. Throughput is one
// item per cycle while rsp_stall is low, set by the single output register.
// Synchronous active-high reset returns the sequencer to idle with zero state.
// ----------------------------------------------------------------------------
module i2c_eeprom_read_sequencer_top #(
   parameter int WRAP_PAGES = eerd_pkg::WRAP_PAGES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eerd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eerd_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);
   import eerd_pkg::*;

   // Every accepted item, whether a command or a bus event report, yields
   // exactly one result item. The sequencer state advances at the accept
   // edge and the result lands in the output register at the same edge.

   logic    accept;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_res;
   logic [7:0] base_ff;

   // The input side stalls only while a result waits and is itself stalled.
   // When the waiting result is taken in this cycle, a new item may enter.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // The base device select byte is written at any edge with the write
   // enable high. It takes effect for the next set-page command or page step.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= DEVICE_BASE_RESET;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   eerd_ctrl #(
      .WRAP_PAGES (WRAP_PAGES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .device_base (base_ff),
      .res         (step_res)
   );

   // Output register: a new result replaces one that is taken this cycle,
   // otherwise the register empties once its item has been taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= step_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // An accepted item always produces a result in the next cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item produced no result");

   // A failure always ends the operation with a stop and leaves the block idle.
   a_fail_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.failed) |->
         (rsp_data.bus_action == ACT_STOP && !rsp_data.busy_res))
      else $error("failure without stop or with busy still set");

   // The reported value is zero unless a completion or a failure is reported.
   a_value_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.done_res && !rsp_data.failed) |->
         (rsp_data.done_value == 8'h00))
      else $error("done value set without completion or failure");

   // Only a send action carries a transmit byte.
   a_tx_only_on_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bus_action != ACT_SEND) |-> (rsp_data.tx_byte == 8'h00))
      else $error("transmit byte set on a non-send action");
`endif

endmodule

/* bench/eerd_checker.sv */
// ----------------------------------------------------------------------------
// eerd_checker
// Watches the request, response and register ports of the EEPROM read
// sequencer. It keeps its own copy of the sequencer state, predicts the
// response of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module eerd_checker #(
   parameter int WRAP_PAGES = eerd_pkg::WRAP_PAGES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  eerd_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  eerd_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   output int                mismatch_count,
   output int                pending_count,
   output int                compared_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import eerd_pkg::*;

   typedef enum logic [8:0] {
      SEQ_IDLE    = 9'b000000001,
      SEQ_SP_DEV  = 9'b000000010,
      SEQ_SP_MSB  = 9'b000000100,
      SEQ_SP_LSB  = 9'b000001000,
      SEQ_SP_STOP = 9'b000010000,
      SEQ_RD_DEV  = 9'b000100000,
      SEQ_RD_NACK = 9'b001000000,
      SEQ_RD_DATA = 9'b010000000,
      SEQ_AUTO    = 9'b100000000
   } seq_state_type;

   seq_state_type seq_state;
   logic [10:0] cur_page;
   logic [15:0] cur_addr;
   logic [7:0]  cur_dsel;
   logic        wrap_pending;
   logic [7:0]  dev_base;
   rsp_type     awaited_q[$];

   // Every mismatch prints one line and is counted.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   function automatic void load_page(input logic [10:0] pg);
      cur_page = pg;
      cur_dsel = dev_base | {4'b0000, pg[10:8], 1'b0};
      cur_addr = {pg[7:0], 8'h00};
   endfunction

   // The busy flag reflects the state after the item has been processed.
   function automatic rsp_type make_rsp(input logic [2:0] act, input logic [7:0] tx,
                                        input logic done, input logic fail,
                                        input logic [7:0] val);
      rsp_type r;
      r.bus_action = act;
      r.tx_byte    = tx;
      r.done_res   = done;
      r.failed     = fail;
      r.done_value = val;
      r.busy_res   = (seq_state != SEQ_IDLE);
      return r;
   endfunction

   // A failing automatic re-address reports the fault but no completion.
   function automatic rsp_type abort_seq(input logic [7:0] status);
      logic commanded;
      commanded    = !wrap_pending;
      wrap_pending = 1'b0;
      seq_state    = SEQ_IDLE;
      return make_rsp(ACT_STOP, 8'h00, commanded, 1'b1, status);
   endfunction

   function automatic void next_address();
      cur_addr = cur_addr + 16'd1;
      if (cur_addr[7:0] != 8'h00) return;
      load_page(cur_page + 11'd1);
      if (cur_addr != 16'h0000) return;
      load_page(cur_page & 11'(WRAP_PAGES - 1));
      wrap_pending = 1'b1;
      seq_state    = SEQ_AUTO;
   endfunction

   function automatic rsp_type sequence_step(input req_type item);
      if (seq_state == SEQ_IDLE) begin
         if (item.cmd == CMD_SET_PAGE) begin
            load_page(item.page);
            wrap_pending = 1'b0;
            seq_state    = SEQ_SP_DEV;
            return make_rsp(ACT_START, 8'h00, 1'b0, 1'b0, 8'h00);
         end
         if (item.cmd == CMD_READ) begin
            seq_state = SEQ_RD_DEV;
            return make_rsp(ACT_START, 8'h00, 1'b0, 1'b0, 8'h00);
         end
         return make_rsp(ACT_NONE, 8'h00, 1'b0, 1'b0, 8'h00);
      end
      if (seq_state == SEQ_AUTO) begin
         seq_state = SEQ_SP_DEV;
         return make_rsp(ACT_START, 8'h00, 1'b0, 1'b0, 8'h00);
      end
      if (item.cmd != CMD_EVENT)
         return make_rsp(ACT_NONE, 8'h00, 1'b0, 1'b0, 8'h00);
      case (seq_state)
         SEQ_SP_DEV: begin
            if (item.bus_status != TWI_START_OK) return abort_seq(item.bus_status);
            seq_state = SEQ_SP_MSB;
            return make_rsp(ACT_SEND, cur_dsel & 8'hFE, 1'b0, 1'b0, 8'h00);
         end
         SEQ_SP_MSB: begin
            if (item.bus_status != TWI_SLA_W_ACK) return abort_seq(item.bus_status);
            seq_state = SEQ_SP_LSB;
            return make_rsp(ACT_SEND, cur_addr[15:8], 1'b0, 1'b0, 8'h00);
         end
         SEQ_SP_LSB: begin
            if (item.bus_status != TWI_DATA_ACK) return abort_seq(item.bus_status);
            seq_state = SEQ_SP_STOP;
            return make_rsp(ACT_SEND, cur_addr[7:0], 1'b0, 1'b0, 8'h00);
         end
         SEQ_SP_STOP: begin
            if (item.bus_status != TWI_DATA_ACK) return abort_seq(item.bus_status);
            seq_state = SEQ_IDLE;
            if (wrap_pending) begin
               wrap_pending = 1'b0;
               return make_rsp(ACT_STOP, 8'h00, 1'b0, 1'b0, 8'h00);
            end
            return make_rsp(ACT_STOP, 8'h00, 1'b1, 1'b0, 8'h00);
         end
         SEQ_RD_DEV: begin
            if (item.bus_status != TWI_START_OK) return abort_seq(item.bus_status);
            seq_state = SEQ_RD_NACK;
            return make_rsp(ACT_SEND, cur_dsel | 8'h01, 1'b0, 1'b0, 8'h00);
         end
         SEQ_RD_NACK: begin
            if (item.bus_status != TWI_SLA_R_ACK) return abort_seq(item.bus_status);
            seq_state = SEQ_RD_DATA;
            return make_rsp(ACT_RECV, 8'h00, 1'b0, 1'b0, 8'h00);
         end
         SEQ_RD_DATA: begin
            if (item.bus_status != TWI_DATA_NACK) return abort_seq(item.bus_status);
            seq_state = SEQ_IDLE;
            next_address();
            return make_rsp(ACT_STOP, 8'h00, 1'b1, 1'b0, item.rx_byte);
         end
         default: begin
            seq_state    = SEQ_IDLE;
            wrap_pending = 1'b0;
            return make_rsp(ACT_NONE, 8'h00, 1'b0, 1'b0, 8'h00);
         end
      endcase
   endfunction

   // A response accepted at an edge belongs to an earlier request, so it is
   // retired before the request of the same edge is predicted.
   always @(posedge clock) begin : watch
      rsp_type wanted;
      if (reset) begin
         seq_state      = SEQ_IDLE;
         cur_page       = '0;
         cur_addr       = '0;
         cur_dsel       = '0;
         wrap_pending   = 1'b0;
         dev_base       = DEVICE_BASE_RESET;
         mismatch_count = 0;
         compared_count = 0;
         awaited_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_q.size() == 0) begin
               report_mismatch("response with nothing expected", 32'(rsp_data), 32'd0);
            end else begin
               wanted = awaited_q.pop_front();
               compared_count++;
               if (rsp_data.bus_action !== wanted.bus_action)
                  report_mismatch("bus_action", 32'(rsp_data.bus_action),
                                  32'(wanted.bus_action));
               if (rsp_data.tx_byte !== wanted.tx_byte)
                  report_mismatch("tx_byte", 32'(rsp_data.tx_byte), 32'(wanted.tx_byte));
               if (rsp_data.done_res !== wanted.done_res)
                  report_mismatch("done_res", 32'(rsp_data.done_res), 32'(wanted.done_res));
               if (rsp_data.failed !== wanted.failed)
                  report_mismatch("failed", 32'(rsp_data.failed), 32'(wanted.failed));
               if (rsp_data.done_value !== wanted.done_value)
                  report_mismatch("done_value", 32'(rsp_data.done_value),
                                  32'(wanted.done_value));
               if (rsp_data.busy_res !== wanted.busy_res)
                  report_mismatch("busy_res", 32'(rsp_data.busy_res), 32'(wanted.busy_res));
            end
         end
         if (req_valid && !req_stall)
            awaited_q.push_back(sequence_step(req_data));
         if (csr_wr_en)
            dev_base = csr_wr_data;
      end
      pending_count = awaited_q.size();
   end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the EEPROM read sequencer with bus event reports and commands, the
// way an I2C master driver would, and lets the checker beside the block
// predict and compare every response. The run covers set-page and read
// sequences, bus faults at every step, commands that arrive while busy, a
// read issued before any page was set and the automatic re-address after a
// 64 KB wrap, under several device base values and with random back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import eerd_pkg::*;

   // The fourth command code means no command; the block gives it no meaning of
   // its own, though like any item it triggers a pending automatic re-address.
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam int WRAP = WRAP_PAGES_DEFAULT;

   // Status codes that a well-behaved bus returns for each sequence, first
   // step in the top byte.
   localparam logic [31:0] SET_PAGE_CODES = {TWI_START_OK, TWI_SLA_W_ACK,
                                             TWI_DATA_ACK, TWI_DATA_ACK};
   localparam logic [31:0] READ_CODES     = {TWI_START_OK, TWI_SLA_R_ACK,
                                             TWI_DATA_NACK, 8'h00};

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   int mismatches;
   int expected_left;
   int results_checked;

   // Stimulus bookkeeping.
   int   items_sent  = 0;
   bit   gaps_on     = 1'b1;
   bit   busy_noise  = 1'b0;
   logic [7:0] mid_base;

   always #2 clock = ~clock;

   i2c_eeprom_read_sequencer_top #(
      .WRAP_PAGES (WRAP)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   eerd_checker #(
      .WRAP_PAGES (WRAP)
   ) i_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatches),
      .pending_count  (expected_left),
      .compared_count (results_checked)
   );

   // Most gaps are short; a few are long. Now and then the sender switches
   // between gapped traffic and back-to-back stretches.
   function automatic int pick_gap();
      int roll;
      if (!gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Roughly one sequence in eight hits a bus fault at a random step.
   function automatic int maybe_fail(input int steps);
      if ($urandom_range(0, 7) != 0) return -1;
      return $urandom_range(0, steps - 1);
   endfunction

   // Presents one item at the falling edge and holds it until the block
   // takes it at a rising edge with req_stall low. Idle cycles before it
   // lower req_valid, each at its own falling edge.
   task automatic offer(input logic [1:0] op, input logic [10:0] pg,
                        input logic [7:0] status, input logic [7:0] rx);
      req_type item;
      int      gap;
      item.cmd        = op;
      item.page       = pg;
      item.bus_status = status;
      item.rx_byte    = rx;
      if ($urandom_range(0, 63) == 0) gaps_on = !gaps_on;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Reports the bus events of one sequence. At fail_at the status is
   // replaced by a wrong one and the sequence ends there, since the block
   // has already gone back to idle. With busy_noise set, stray commands are
   // slipped in between events; the block must ignore them.
   task automatic bus_events(input logic [31:0] codes, input int steps, input int fail_at,
                             input logic [7:0] bad, input logic [7:0] last_rx);
      logic [7:0] status;
      for (int i = 0; i < steps; i++) begin
         if (busy_noise && $urandom_range(0, 11) == 0)
            offer(2'($urandom_range(CMD_SET_PAGE, CMD_NONE)), 11'($urandom),
                  8'($urandom), 8'($urandom));
         status = codes[31 - 8*i -: 8];
         if (i == fail_at) status = (bad == status) ? ~status : bad;
         offer(CMD_EVENT, 11'($urandom), status,
               (i == steps - 1) ? last_rx : 8'($urandom));
         if (i == fail_at) break;
      end
   endtask

   task automatic set_page_seq(input logic [10:0] pg, input int fail_at,
                               input logic [7:0] bad);
      offer(CMD_SET_PAGE, pg, 8'($urandom), 8'($urandom));
      bus_events(SET_PAGE_CODES, 4, fail_at, bad, 8'($urandom));
   endtask

   task automatic read_seq(input int fail_at, input logic [7:0] bad, input logic [7:0] rx);
      offer(CMD_READ, 11'($urandom), 8'($urandom), 8'($urandom));
      bus_events(READ_CODES, 3, fail_at, bad, rx);
   endtask

   // Mostly well-formed sequences with random content, plus stray items:
   // random commands and events that may land while idle or mid-sequence.
   task automatic mixed_traffic(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2:       set_page_seq(11'($urandom), maybe_fail(4), 8'($urandom));
            3, 4, 5, 6, 7: read_seq(maybe_fail(3), 8'($urandom), 8'($urandom));
            8:             offer(2'($urandom), 11'($urandom), 8'($urandom), 8'($urandom));
            default:       offer(CMD_EVENT, 11'($urandom), 8'($urandom), 8'($urandom));
         endcase
      end
   endtask

   // A page whose low byte is all ones starts at the last 256 bytes of a
   // 64 KB block, so 256 good reads wrap the word address to zero. The item
   // after that read restarts the set-page sequence whatever it carries.
   task automatic cross_64k(input logic [10:0] pg, input int auto_fail);
      // An event with a status that no step expects closes any sequence that
      // stray items left open, so the set-page command below is taken.
      offer(CMD_EVENT, 11'($urandom), 8'hFF, 8'($urandom));
      set_page_seq(pg, -1, 8'h00);
      repeat (256) read_seq(-1, 8'h00, 8'($urandom));
      offer(2'($urandom), 11'($urandom), 8'($urandom), 8'($urandom));
      bus_events(SET_PAGE_CODES, 4, auto_fail, 8'($urandom), 8'($urandom));
      read_seq(-1, 8'h00, 8'($urandom));
   endtask

   // Register writes happen only once every expected response is back. Each
   // item gives exactly one response, so a short pause is enough for the
   // block to settle.
   task automatic write_base(input logic [7:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Receiver: stretches with no back-pressure alternate with stretches of
   // random stalls. Twice it holds off for a long run of cycles, counted
   // here, while the sender keeps offering, so the block fills and stalls
   // its input.
   initial begin : receiver
      int  cycles_seen;
      int  stall_left;
      int  hold_left;
      int  stretch;
      bit  quiet;
      cycles_seen = 0;
      stall_left  = 0;
      hold_left   = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stretch = $urandom_range(20, 150);
         quiet   = ($urandom_range(0, 3) == 0);
         repeat (stretch) begin
            @(negedge clock);
            cycles_seen++;
            if (hold_left > 0) begin
               rsp_stall <= 1'b1;
               hold_left--;
            end else if (cycles_seen == 150 || cycles_seen == 2600) begin
               rsp_stall <= 1'b1;
               hold_left = 99;
            end else if (stall_left > 0) begin
               rsp_stall <= 1'b1;
               stall_left--;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
               rsp_stall <= 1'b1;
               stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 24)
                                                         : $urandom_range(0, 2);
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Generous fixed limit: far above the slowest legal run of this stimulus.
   initial begin : watchdog
      #4ms;
      $display("Timeout with %0d responses still expected", expected_left);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int auto_fail;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed part, device base at its reset value. The first read comes
      // before any page was set, so it uses the all-zero device select.
      offer(CMD_EVENT, 11'h7FF, 8'hFF, 8'hFF);
      offer(CMD_NONE, 11'h000, 8'h00, 8'h00);
      read_seq(-1, 8'h00, 8'hFF);
      set_page_seq(11'h7FF, -1, 8'h00);
      // Start fails on the first status.
      set_page_seq(11'h000, 0, 8'hFF);
      // A read that sees a command while busy, then a wrong final status.
      offer(CMD_READ, 11'h000, 8'h00, 8'h00);
      offer(CMD_SET_PAGE, 11'h555, 8'h00, 8'h00);
      bus_events(READ_CODES, 3, 2, 8'h00, 8'hA5);
      read_seq(-1, 8'h00, 8'h00);

      // Random part under several device base values, the extremes first.
      busy_noise = 1'b1;
      write_base(8'h00);
      mixed_traffic(30);
      write_base(8'hFE);
      mixed_traffic(30);

      // The page after the 64 KB crossing lies past the wrap size and is
      // masked down. In about half of the runs the automatic re-address
      // meets a bus fault at a random step.
      mid_base  = 8'($urandom_range(0, 254));
      auto_fail = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 3);
      write_base(mid_base);
      cross_64k(11'h2FF, auto_fail);
      mixed_traffic(10);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      repeat (4) @(negedge clock);

      $display("Summary: %0d request items driven, %0d responses compared, %0d mismatches.",
               items_sent, results_checked, mismatches);
      $display("Device base 0xA0, 0x00, 0xFE and 0x%0h; one 64 KB wrap, re-address %s.",
               mid_base, (auto_fail < 0) ? "clean" : "with a bus fault");
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* i2c_eeprom_read_sequencer_top.f */
sv/eerd_pkg.sv
sv/eerd_ctrl.sv
sv/i2c_eeprom_read_sequencer_top.sv
bench/eerd_checker.sv
bench/testbench.sv
